[rtl/phim_pkg.sv]
// ----------------------------------------------------------------------------
// phim_pkg: shared types and constants for the pixel hit isolation matcher
// Frame geometry, action codes, beat structs and the window pattern tables.
// ----------------------------------------------------------------------------
package phim_pkg;

  // frame geometry
  localparam int FRAME_SIDE = 256;
  localparam int VALUE_BITS = 14;
  localparam int COORD_W    = $clog2(FRAME_SIDE);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELLS      = FRAME_SIDE * FRAME_SIDE;
  localparam int EXT_W      = 11;
  localparam int RAM_W      = VALUE_BITS + 1;

  // action codes
  typedef enum logic [2:0] {
    ACT_LOAD  = 3'd0,
    ACT_ISO   = 3'd1,
    ACT_PAIR  = 3'd2,
    ACT_CTRL  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [13:0] hit_value;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic        transposed;
    logic [13:0] value_low;
    logic [13:0] value_high;
  } out_item_t;

  // command between front and back
  typedef struct packed {
    action_t               action;
    logic [7:0]            col;
    logic [7:0]            row;
    logic [VALUE_BITS-1:0] value;
  } cmd_t;

  // candidates, bit dc*4+dr of the 4x4 block around the origin:
  // 0 iso A, 1 iso A tr, 2 iso B, 3 iso B tr, 4 pair, 5 pair tr, 6 ctrl, 7 ctrl tr
  localparam logic [15:0] PAT_EXP [8] = '{
    16'h0020, 16'h0020, 16'h0200, 16'h0040,
    16'h0220, 16'h0060, 16'h2020, 16'h00A0
  };
  localparam logic [7:0] PAT_TR  = 8'b1010_1010;
  localparam logic [7:0] PAT_TWO = 8'b1111_0000;
  // hit cell of singles, second hit cell of pairs
  localparam logic [3:0] PAT_K1 [8] = '{
    4'd5, 4'd5, 4'd9, 4'd6, 4'd9, 4'd6, 4'd13, 4'd7
  };
  localparam logic [3:0]  K_FIRST = 4'd5;
  localparam logic [15:0] WIN_NRM = 16'h7777;
  localparam logic [15:0] WIN_TR  = 16'h0FFF;

  // frame address of origin plus offset
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] c, input logic [7:0] r,
                                                  input logic [1:0] dc, input logic [1:0] dr);
    logic [EXT_W-1:0] ec;
    logic [EXT_W-1:0] er;
    ec = {3'b000, c} + {9'd0, dc};
    er = {3'b000, r} + {9'd0, dr};
    return {ec[COORD_W-1:0], er[COORD_W-1:0]};
  endfunction

endpackage

[rtl/phim_ram.sv]
// ----------------------------------------------------------------------------
// phim_ram: generic memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phim_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/phim_front.sv]
// ----------------------------------------------------------------------------
// phim_front: input classification and command queue
// Drops ignored actions and off-frame loads, queues the rest for the back end.
// ----------------------------------------------------------------------------
module phim_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  phim_pkg::in_item_t item,
  output logic               full,
  output logic               cmd_valid,
  output phim_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import phim_pkg::*;

  cmd_t       q_r [4];
  logic [1:0] wp_r;
  logic [1:0] rp_r;
  logic [2:0] cnt_r;
  logic       keep;
  logic       enq;
  logic       deq;
  cmd_t       c_in;

  // classify the incoming beat
  always_comb begin
    c_in.action = action_t'(item.action);
    c_in.col    = item.pixel_col;
    c_in.row    = item.pixel_row;
    c_in.value  = VALUE_BITS'(item.hit_value);
    case (item.action)
      ACT_LOAD: begin
        keep = ({3'b000, item.pixel_col} < EXT_W'(FRAME_SIDE)) &&
               ({3'b000, item.pixel_row} < EXT_W'(FRAME_SIDE));
      end
      ACT_ISO, ACT_PAIR, ACT_CTRL, ACT_CLEAR: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign full      = (cnt_r == 3'd4);
  assign cmd_valid = (cnt_r != 3'd0);
  assign cmd       = q_r[rp_r];
  assign enq       = push && keep;
  assign deq       = cmd_pop && cmd_valid;

  // hold queued commands
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= c_in;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (enq) wp_r <= wp_r + 2'd1;
      if (deq) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b00, enq} - {2'b00, deq};
    end
  end

endmodule

[rtl/phim_out_q.sv]
// ----------------------------------------------------------------------------
// phim_out_q: result queue
// Two-entry queue that parts the back end from the result receiver.
// ----------------------------------------------------------------------------
module phim_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  phim_pkg::out_item_t din,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output phim_pkg::out_item_t dout
);
  import phim_pkg::*;

  out_item_t  q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       enq;
  logic       deq;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = q_r[rp_r];
  assign enq   = push && !full;
  assign deq   = pop && !empty;

  // hold results
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wp_r] <= din;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (enq) wp_r <= ~wp_r;
      if (deq) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

[rtl/phim_back.sv]
// ----------------------------------------------------------------------------
// phim_back: frame memory and command sequencer
// Loads hits, clears the frame, reads and tests a 4x4 block for find actions.
// ----------------------------------------------------------------------------
module phim_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  phim_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                init_busy,
  output logic                res_push,
  output phim_pkg::out_item_t res,
  input  logic                res_full
);
  import phim_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_READ, S_WAIT, S_EVAL, S_MARK1, S_MARK2
  } state_t;

  state_t                state_r;
  logic                  push_st_r;
  logic [ADDR_W-1:0]     swp_r;
  logic [3:0]            k_r;
  logic                  rd_vld_r;
  logic [3:0]            rd_k_r;
  logic [15:0]           occ_r;
  logic [VALUE_BITS-1:0] val_r [16];
  cmd_t                  cur_r;
  logic [2:0]            sel_r;
  out_item_t             res_r;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [RAM_W-1:0]      wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [RAM_W-1:0]      rdata;

  logic                  nrm_ok;
  logic                  tr_ok;
  logic [2:0]            first;
  logic [2:0]            last;
  logic                  found;
  logic [2:0]            sel;
  logic [VALUE_BITS-1:0] v0;
  logic [VALUE_BITS-1:0] v1;
  logic [3:0]            mk;

  phim_ram #(.WIDTH(RAM_W), .DEPTH(CELLS)) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign init_busy = (state_r == S_INIT);
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid && !push_st_r;
  assign res_push  = push_st_r && !res_full;
  assign res       = res_r;
  assign raddr     = cell_addr(cur_r.col, cur_r.row, k_r[3:2], k_r[1:0]);
  assign mk        = (state_r == S_MARK1 && PAT_TWO[sel_r]) ? K_FIRST : PAT_K1[sel_r];

  // drive frame writes: sweep, load or visited mark
  always_comb begin
    we    = 1'b0;
    waddr = swp_r;
    wdata = '0;
    case (state_r)
      S_INIT, S_CLEAR: we = 1'b1;
      S_IDLE: begin
        if (cmd_pop && cmd.action == ACT_LOAD) begin
          we    = 1'b1;
          waddr = cell_addr(cmd.col, cmd.row, 2'd0, 2'd0);
          wdata = {1'b1, cmd.value};
        end
      end
      S_MARK1, S_MARK2: begin
        we    = 1'b1;
        waddr = cell_addr(cur_r.col, cur_r.row, mk[3:2], mk[1:0]);
      end
      default: we = 1'b0;
    endcase
  end

  // test candidates in priority order
  always_comb begin
    nrm_ok = ({3'b000, cur_r.col} + EXT_W'(4) < EXT_W'(FRAME_SIDE)) &&
             ({3'b000, cur_r.row} + EXT_W'(3) < EXT_W'(FRAME_SIDE));
    tr_ok  = ({3'b000, cur_r.col} + EXT_W'(3) < EXT_W'(FRAME_SIDE)) &&
             ({3'b000, cur_r.row} + EXT_W'(4) < EXT_W'(FRAME_SIDE));
    case (cur_r.action)
      ACT_ISO:  begin first = 3'd0; last = 3'd3; end
      ACT_PAIR: begin first = 3'd4; last = 3'd5; end
      default:  begin first = 3'd6; last = 3'd7; end
    endcase
    found = 1'b0;
    sel   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (3'(i) >= first && 3'(i) <= last &&
          (PAT_TR[i] ? (tr_ok && (occ_r & WIN_TR) == PAT_EXP[i])
                     : (nrm_ok && (occ_r & WIN_NRM) == PAT_EXP[i]))) begin
        found = 1'b1;
        sel   = 3'(i);
      end
    end
    v0 = PAT_TWO[sel] ? val_r[K_FIRST] : val_r[PAT_K1[sel]];
    v1 = PAT_TWO[sel] ? val_r[PAT_K1[sel]] : v0;
  end

  // capture read data of the block
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      occ_r[rd_k_r] <= rdata[VALUE_BITS];
      val_r[rd_k_r] <= rdata[VALUE_BITS-1:0];
    end
  end

  // sequence commands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      swp_r     <= '0;
      k_r       <= '0;
      rd_vld_r  <= 1'b0;
      push_st_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_READ);
      rd_k_r   <= k_r;
      if (res_push) push_st_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLEAR: begin
          swp_r <= swp_r + ADDR_W'(1);
          if (&swp_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cur_r <= cmd;
            k_r   <= '0;
            swp_r <= '0;
            case (cmd.action)
              ACT_LOAD:  state_r <= S_IDLE;
              ACT_CLEAR: state_r <= S_CLEAR;
              default:   state_r <= S_READ;
            endcase
          end
        end
        S_READ: begin
          k_r <= k_r + 4'd1;
          if (&k_r) state_r <= S_WAIT;
        end
        S_WAIT: state_r <= S_EVAL;
        S_EVAL: begin
          sel_r            <= sel;
          res_r.matched    <= found;
          res_r.transposed <= found && PAT_TR[sel];
          res_r.value_low  <= found ? 14'((v0 < v1) ? v0 : v1) : 14'd0;
          res_r.value_high <= found ? 14'((v0 < v1) ? v1 : v0) : 14'd0;
          if (found) begin
            state_r <= S_MARK1;
          end else begin
            push_st_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        S_MARK1: begin
          if (PAT_TWO[sel_r]) begin
            state_r <= S_MARK2;
          end else begin
            push_st_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        S_MARK2: begin
          push_st_r <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/pixel_hit_isolation_matcher.sv]
// ----------------------------------------------------------------------------
// pixel_hit_isolation_matcher: hit-or-miss window matcher over a pixel frame
//
// Input queue port: drive in_item and in_push; a beat is taken when in_full
// is low. Action load writes one pixel, clear empties the frame (all 65536
// cells, one cell a cycle), find tests a window at the origin.
// Each find yields one result beat on out_item while out_empty is low; it is
// taken with out_pop. Other actions give no result.
// A find consists of 16 reads of the 4x4 block through
// the single frame memory read port, evaluation, up to two visited marks and
// the result push. A four-deep command queue lets loads and finds be taken
// while the back end works; a two-deep result queue absorbs receiver stalls,
// and the back end waits when it is full.
// After reset the frame memory is cleared by a sweep over all 65536 cells,
// with in_full held high throughout.
// ----------------------------------------------------------------------------
module pixel_hit_isolation_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  phim_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output phim_pkg::out_item_t out_item
);
  import phim_pkg::*;

  logic      fq_full;
  logic      init_busy;
  logic      cmd_valid;
  logic      cmd_pop;
  cmd_t      cmd;
  logic      res_push;
  logic      res_full;
  out_item_t res;

  assign in_full = fq_full || init_busy;

  phim_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push && !in_full),
    .item      (in_item),
    .full      (fq_full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  phim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .init_busy (init_busy),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  phim_out_q u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (out_item)
  );

`ifndef SYNTH
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid) else $error("command popped from empty queue");
  a_reset_full: assert property (@(posedge clk)
    !rst_n |=> in_full) else $error("input open during frame clear sweep");
`endif

endmodule
